/* rtl/box_overlap_ratios_core_defines.svh */
// ---------------------------------------------------------------------------
// box overlap ratios: assertion macros
// shared property shapes for the checker files
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_RATIOS_CORE_DEFINES_SVH
`define BOX_OVERLAP_RATIOS_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BOR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box overlap ratios check failed");

// next-cycle implication, reset masks the check
`define BOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box overlap ratios check failed");

`endif

/* rtl/bor_pkg.sv */
// ---------------------------------------------------------------------------
// bor_pkg
// shared constants and types of the box overlap ratios core
// ---------------------------------------------------------------------------
package bor_pkg;

   // default coordinate and fraction widths
   localparam int unsigned COORD_BITS_DEFAULT    = 13;
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;

   // zero-divisor flags that travel with each word
   typedef struct packed {
      logic union_empty;
      logic first_empty;
   } flag_type;

endpackage

/* rtl/bor_geom.sv */
// ---------------------------------------------------------------------------
// bor_geom
// four-stage front end: spans, areas, area sum, union and zero flags
// ---------------------------------------------------------------------------
module bor_geom #(
   parameter int unsigned COORD_BITS = bor_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COORD_BITS-1:0]   first_left,
   input  logic [COORD_BITS-1:0]   first_top,
   input  logic [COORD_BITS-1:0]   first_right,
   input  logic [COORD_BITS-1:0]   first_bottom,
   input  logic [COORD_BITS-1:0]   second_left,
   input  logic [COORD_BITS-1:0]   second_top,
   input  logic [COORD_BITS-1:0]   second_right,
   input  logic [COORD_BITS-1:0]   second_bottom,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2*COORD_BITS-1:0] inter_area,
   output logic [2*COORD_BITS-1:0] first_area,
   output logic [2*COORD_BITS:0]   union_area,
   output bor_pkg::flag_type       flags
);
   import bor_pkg::*;

   localparam int unsigned AREA_BITS = 2 * COORD_BITS;
   localparam int unsigned SUM_BITS  = AREA_BITS + 1;
   localparam int unsigned STAGES    = 4;

   // clamped span: hi - lo, or zero when hi is not above lo
   function automatic logic [COORD_BITS-1:0] span(input logic [COORD_BITS-1:0] lo,
                                                  input logic [COORD_BITS-1:0] hi);
      logic [COORD_BITS:0] diff;
      diff = {1'b0, hi} - {1'b0, lo};
      return diff[COORD_BITS] ? '0 : diff[COORD_BITS-1:0];
   endfunction

   logic [STAGES:1] valid_ff, valid_in, stage_ready, prev_valid;

   // stage 1: widths and heights
   logic [COORD_BITS-1:0] w1_ff, h1_ff, w2_ff, h2_ff, iw_ff, ih_ff;
   logic [COORD_BITS-1:0] w1_in, h1_in, w2_in, h2_in, iw_in, ih_in;
   logic [COORD_BITS-1:0] il, it, ir, ib;

   // stage 2: products
   logic [AREA_BITS-1:0] a1_s2_ff, a2_s2_ff, in_s2_ff;
   logic [AREA_BITS-1:0] a1_s2_in, a2_s2_in, in_s2_in;

   // stage 3: area sum
   logic [SUM_BITS-1:0]  sum_s3_ff, sum_s3_in;
   logic [AREA_BITS-1:0] a1_s3_ff, in_s3_ff;
   logic                 fe_s3_ff, fe_s3_in;

   // stage 4: union
   logic [SUM_BITS-1:0]  uni_s4_ff, uni_s4_in;
   logic [AREA_BITS-1:0] a1_s4_ff, in_s4_ff;
   flag_type             flags_s4_ff, flags_s4_in;

   // ready ripples back from the output, a slot takes a word when empty or leaving
   always_comb begin
      stage_ready[STAGES] = !valid_ff[STAGES] || out_ready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      prev_valid[1] = in_valid;
      for (int i = 2; i <= STAGES; i++) begin
         prev_valid[i] = valid_ff[i-1];
      end
      for (int i = 1; i <= STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? prev_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1 logic: own spans and overlap rectangle
   always_comb begin
      il    = (first_left  > second_left)   ? first_left   : second_left;
      it    = (first_top   > second_top)    ? first_top    : second_top;
      ir    = (first_right < second_right)  ? first_right  : second_right;
      ib    = (first_bottom < second_bottom) ? first_bottom : second_bottom;
      w1_in = span(first_left, first_right);
      h1_in = span(first_top, first_bottom);
      w2_in = span(second_left, second_right);
      h2_in = span(second_top, second_bottom);
      iw_in = span(il, ir);
      ih_in = span(it, ib);
   end

   // stage 2 logic: three parallel multiplies
   always_comb begin
      a1_s2_in = w1_ff * h1_ff;
      a2_s2_in = w2_ff * h2_ff;
      in_s2_in = iw_ff * ih_ff;
   end

   // stage 3 logic: sum of both areas, first area zero check
   always_comb begin
      sum_s3_in = {1'b0, a1_s2_ff} + {1'b0, a2_s2_ff};
      fe_s3_in  = (a1_s2_ff == '0);
   end

   // stage 4 logic: union, never negative since overlap fits in each area
   always_comb begin
      uni_s4_in               = sum_s3_ff - {1'b0, in_s3_ff};
      flags_s4_in.union_empty = (sum_s3_ff == {1'b0, in_s3_ff});
      flags_s4_in.first_empty = fe_s3_ff;
   end

   // payload registers load only when a word moves in
   always_ff @(posedge clock) begin
      if (stage_ready[1] && prev_valid[1]) begin
         w1_ff <= w1_in;
         h1_ff <= h1_in;
         w2_ff <= w2_in;
         h2_ff <= h2_in;
         iw_ff <= iw_in;
         ih_ff <= ih_in;
      end
      if (stage_ready[2] && prev_valid[2]) begin
         a1_s2_ff <= a1_s2_in;
         a2_s2_ff <= a2_s2_in;
         in_s2_ff <= in_s2_in;
      end
      if (stage_ready[3] && prev_valid[3]) begin
         sum_s3_ff <= sum_s3_in;
         a1_s3_ff  <= a1_s2_ff;
         in_s3_ff  <= in_s2_ff;
         fe_s3_ff  <= fe_s3_in;
      end
      if (stage_ready[4] && prev_valid[4]) begin
         uni_s4_ff   <= uni_s4_in;
         a1_s4_ff    <= a1_s3_ff;
         in_s4_ff    <= in_s3_ff;
         flags_s4_ff <= flags_s4_in;
      end
   end

   assign in_ready   = stage_ready[1];
   assign out_valid  = valid_ff[STAGES];
   assign inter_area = in_s4_ff;
   assign first_area = a1_s4_ff;
   assign union_area = uni_s4_ff;
   assign flags      = flags_s4_ff;

endmodule

/* rtl/bor_div_stage.sv */
// ---------------------------------------------------------------------------
// bor_div_stage
// one restoring division step for both ratios, with its pipeline register
// ---------------------------------------------------------------------------
module bor_div_stage #(
   parameter int unsigned AREA_BITS = 2 * bor_pkg::COORD_BITS_DEFAULT,
   parameter int unsigned QUO_BITS  = bor_pkg::FRACTION_BITS_DEFAULT + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [AREA_BITS-1:0]   in_area,
   input  logic [AREA_BITS:0]     in_den_u,
   input  logic [AREA_BITS+1:0]   in_rem_u,
   input  logic [QUO_BITS-1:0]    in_quo_u,
   input  logic [AREA_BITS:0]     in_den_f,
   input  logic [AREA_BITS+1:0]   in_rem_f,
   input  logic [QUO_BITS-1:0]    in_quo_f,
   input  bor_pkg::flag_type      in_flags,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [AREA_BITS-1:0]   out_area,
   output logic [AREA_BITS:0]     out_den_u,
   output logic [AREA_BITS+1:0]   out_rem_u,
   output logic [QUO_BITS-1:0]    out_quo_u,
   output logic [AREA_BITS:0]     out_den_f,
   output logic [AREA_BITS+1:0]   out_rem_f,
   output logic [QUO_BITS-1:0]    out_quo_f,
   output bor_pkg::flag_type      out_flags
);
   import bor_pkg::*;

   localparam int unsigned DEN_BITS = AREA_BITS + 1;
   localparam int unsigned REM_BITS = DEN_BITS + 1;

   // compare-subtract, then shift the partial remainder for the next bit
   function automatic logic [REM_BITS+QUO_BITS-1:0] div_bit(
      input logic [REM_BITS-1:0] rem,
      input logic [DEN_BITS-1:0] den,
      input logic [QUO_BITS-1:0] quo
   );
      logic [REM_BITS:0]   diff;
      logic                take;
      logic [REM_BITS-1:0] kept;
      diff = {1'b0, rem} - {2'b00, den};
      take = !diff[REM_BITS];
      kept = take ? diff[REM_BITS-1:0] : rem;
      return {kept[REM_BITS-2:0], 1'b0, quo[QUO_BITS-2:0], take};
   endfunction

   logic                  valid_ff, valid_in;
   logic [AREA_BITS-1:0]  area_ff;
   logic [DEN_BITS-1:0]   den_u_ff, den_f_ff;
   logic [REM_BITS-1:0]   rem_u_ff, rem_f_ff, rem_u_in, rem_f_in;
   logic [QUO_BITS-1:0]   quo_u_ff, quo_f_ff, quo_u_in, quo_f_in;
   flag_type              flags_ff;

   // slot is free when empty or when its word leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      {rem_u_in, quo_u_in} = div_bit(in_rem_u, in_den_u, in_quo_u);
      {rem_f_in, quo_f_in} = div_bit(in_rem_f, in_den_f, in_quo_f);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         area_ff  <= in_area;
         den_u_ff <= in_den_u;
         rem_u_ff <= rem_u_in;
         quo_u_ff <= quo_u_in;
         den_f_ff <= in_den_f;
         rem_f_ff <= rem_f_in;
         quo_f_ff <= quo_f_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_area  = area_ff;
   assign out_den_u = den_u_ff;
   assign out_rem_u = rem_u_ff;
   assign out_quo_u = quo_u_ff;
   assign out_den_f = den_f_ff;
   assign out_rem_f = rem_f_ff;
   assign out_quo_f = quo_f_ff;
   assign out_flags = flags_ff;

endmodule

/* rtl/box_overlap_ratios_core.sv */
// ---------------------------------------------------------------------------
// box_overlap_ratios_core
// overlap area, intersection over union and intersection over first area
// ---------------------------------------------------------------------------
// Takes one pair of boxes per cycle unless a stalled result side backs up the
// pipeline, and returns one result word per pair, in order. Four front stages
// find the clamped spans, the three areas, their sum and the union; then
// FRACTION_BITS + 1 stages each resolve one quotient bit of both ratios with
// a restoring compare-subtract. Every stage holds its own valid bit and fills
// whenever it is empty, so bubbles close up under a stalled output. A zero
// union or zero first area gives a ratio of zero with the matching empty flag
// set. No reset-time work is needed.
// ---------------------------------------------------------------------------
module box_overlap_ratios_core #(
   parameter int unsigned COORD_BITS    = bor_pkg::COORD_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = bor_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_BITS-1:0]   req_first_left,
   input  logic [COORD_BITS-1:0]   req_first_top,
   input  logic [COORD_BITS-1:0]   req_first_right,
   input  logic [COORD_BITS-1:0]   req_first_bottom,
   input  logic [COORD_BITS-1:0]   req_second_left,
   input  logic [COORD_BITS-1:0]   req_second_top,
   input  logic [COORD_BITS-1:0]   req_second_right,
   input  logic [COORD_BITS-1:0]   req_second_bottom,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2*COORD_BITS-1:0] rsp_overlap_area,
   output logic [FRACTION_BITS:0]  rsp_union_ratio,
   output logic [FRACTION_BITS:0]  rsp_first_ratio,
   output logic                    rsp_union_empty,
   output logic                    rsp_first_empty
);
   import bor_pkg::*;

   localparam int unsigned AREA_BITS = 2 * COORD_BITS;
   localparam int unsigned DEN_BITS  = AREA_BITS + 1;
   localparam int unsigned REM_BITS  = DEN_BITS + 1;
   localparam int unsigned QUO_BITS  = FRACTION_BITS + 1;

   // divider chain words, index 0 is the front end output
   logic                  st_valid [QUO_BITS+1];
   logic                  st_ready [QUO_BITS+1];
   logic [AREA_BITS-1:0]  st_area  [QUO_BITS+1];
   logic [DEN_BITS-1:0]   st_den_u [QUO_BITS+1];
   logic [REM_BITS-1:0]   st_rem_u [QUO_BITS+1];
   logic [QUO_BITS-1:0]   st_quo_u [QUO_BITS+1];
   logic [DEN_BITS-1:0]   st_den_f [QUO_BITS+1];
   logic [REM_BITS-1:0]   st_rem_f [QUO_BITS+1];
   logic [QUO_BITS-1:0]   st_quo_f [QUO_BITS+1];
   flag_type              st_flags [QUO_BITS+1];

   logic [AREA_BITS-1:0]  geom_inter, geom_first;
   logic [DEN_BITS-1:0]   geom_union;

   // front end: spans, areas, union
   bor_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .first_left    (req_first_left),
      .first_top     (req_first_top),
      .first_right   (req_first_right),
      .first_bottom  (req_first_bottom),
      .second_left   (req_second_left),
      .second_top    (req_second_top),
      .second_right  (req_second_right),
      .second_bottom (req_second_bottom),
      .out_valid     (st_valid[0]),
      .out_ready     (st_ready[0]),
      .inter_area    (geom_inter),
      .first_area    (geom_first),
      .union_area    (geom_union),
      .flags         (st_flags[0])
   );

   // seed both dividers: overlap area is the dividend, never above the divisor
   assign st_area[0]  = geom_inter;
   assign st_den_u[0] = geom_union;
   assign st_rem_u[0] = {2'b00, geom_inter};
   assign st_quo_u[0] = '0;
   assign st_den_f[0] = {1'b0, geom_first};
   assign st_rem_f[0] = {2'b00, geom_inter};
   assign st_quo_f[0] = '0;

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      bor_div_stage #(
         .AREA_BITS (AREA_BITS),
         .QUO_BITS  (QUO_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[k]),
         .in_ready  (st_ready[k]),
         .in_area   (st_area[k]),
         .in_den_u  (st_den_u[k]),
         .in_rem_u  (st_rem_u[k]),
         .in_quo_u  (st_quo_u[k]),
         .in_den_f  (st_den_f[k]),
         .in_rem_f  (st_rem_f[k]),
         .in_quo_f  (st_quo_f[k]),
         .in_flags  (st_flags[k]),
         .out_valid (st_valid[k+1]),
         .out_ready (st_ready[k+1]),
         .out_area  (st_area[k+1]),
         .out_den_u (st_den_u[k+1]),
         .out_rem_u (st_rem_u[k+1]),
         .out_quo_u (st_quo_u[k+1]),
         .out_den_f (st_den_f[k+1]),
         .out_rem_f (st_rem_f[k+1]),
         .out_quo_f (st_quo_f[k+1]),
         .out_flags (st_flags[k+1])
      );
   end

   // last divider stage doubles as the output register
   assign st_ready[QUO_BITS] = rsp_ready;
   assign rsp_valid          = st_valid[QUO_BITS];
   assign rsp_overlap_area   = st_area[QUO_BITS];
   assign rsp_union_empty    = st_flags[QUO_BITS].union_empty;
   assign rsp_first_empty    = st_flags[QUO_BITS].first_empty;

   // a zero divisor drives its quotient to all ones, so force zero
   assign rsp_union_ratio = st_flags[QUO_BITS].union_empty ? '0 : st_quo_u[QUO_BITS];
   assign rsp_first_ratio = st_flags[QUO_BITS].first_empty ? '0 : st_quo_f[QUO_BITS];

endmodule

/* rtl/bor_checker.sv */
// ---------------------------------------------------------------------------
// bor_checker
// port-level checks on result words of the box overlap ratios core
// ---------------------------------------------------------------------------
`include "box_overlap_ratios_core_defines.svh"

module bor_checker #(
   parameter int unsigned COORD_BITS    = bor_pkg::COORD_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = bor_pkg::FRACTION_BITS_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [2*COORD_BITS-1:0] rsp_overlap_area,
   input logic [FRACTION_BITS:0]  rsp_union_ratio,
   input logic [FRACTION_BITS:0]  rsp_first_ratio,
   input logic                    rsp_union_empty,
   input logic                    rsp_first_empty
);

   localparam logic [FRACTION_BITS:0] RATIO_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // empty union means an empty first box too, and a zero ratio
   `BOR_ASSERT_NOW(a_union_empty, clock, reset, rsp_valid && rsp_union_empty, rsp_union_ratio == '0 && rsp_first_empty)

   // empty first box gives a zero ratio
   `BOR_ASSERT_NOW(a_first_empty, clock, reset, rsp_valid && rsp_first_empty, rsp_first_ratio == '0)

   // union covers the first box, so its ratio is the smaller one, both at most one
   `BOR_ASSERT_NOW(a_ratio_order, clock, reset, rsp_valid, rsp_union_ratio <= rsp_first_ratio && rsp_first_ratio <= RATIO_ONE)

   // no overlap, no ratio
   `BOR_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid && rsp_overlap_area == '0, rsp_union_ratio == '0 && rsp_first_ratio == '0)

   // a stalled word stays valid, with its overlap area and union ratio held
   `BOR_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_overlap_area) && $stable(rsp_union_ratio))

endmodule

bind box_overlap_ratios_core bor_checker #(
   .COORD_BITS    (COORD_BITS),
   .FRACTION_BITS (FRACTION_BITS)
) u_bor_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_overlap_area (rsp_overlap_area),
   .rsp_union_ratio  (rsp_union_ratio),
   .rsp_first_ratio  (rsp_first_ratio),
   .rsp_union_empty  (rsp_union_empty),
   .rsp_first_empty  (rsp_first_empty)
);

/* dv/tb_box_overlap_ratios_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_box_overlap_ratios_core
// self-checking bench for the box overlap ratios core
// ---------------------------------------------------------------------------
// Sends box pairs through the request channel in bursts with random gaps while
// the result side stalls on its own rolling pattern. Every accepted pair is
// run through a local model of the overlap math and queued; every result word
// is checked field by field against the oldest queued entry. A directed set
// covers empty, inverted, nested, touching and full-frame boxes, then random
// phases cover overlapping pairs, raw coordinates and shared-edge pairs.
// ---------------------------------------------------------------------------
module tb_box_overlap_ratios_core;

   localparam int unsigned CB = bor_pkg::COORD_BITS_DEFAULT;
   localparam int unsigned FB = bor_pkg::FRACTION_BITS_DEFAULT;
   localparam int COORD_MAX   = (1 << CB) - 1;

   typedef struct packed {
      logic [CB-1:0] left;
      logic [CB-1:0] top;
      logic [CB-1:0] right;
      logic [CB-1:0] bottom;
   } box_type;

   typedef struct packed {
      logic [2*CB-1:0] area;
      logic [FB:0]     union_ratio;
      logic [FB:0]     first_ratio;
      logic            union_empty;
      logic            first_empty;
   } overlap_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [CB-1:0]   req_first_left;
   logic [CB-1:0]   req_first_top;
   logic [CB-1:0]   req_first_right;
   logic [CB-1:0]   req_first_bottom;
   logic [CB-1:0]   req_second_left;
   logic [CB-1:0]   req_second_top;
   logic [CB-1:0]   req_second_right;
   logic [CB-1:0]   req_second_bottom;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [2*CB-1:0] rsp_overlap_area;
   logic [FB:0]     rsp_union_ratio;
   logic [FB:0]     rsp_first_ratio;
   logic            rsp_union_empty;
   logic            rsp_first_empty;

   overlap_type pending_overlaps[$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   logic [31:0] stall_pattern  = '1;
   logic [4:0]  stall_tick     = '0;

   box_overlap_ratios_core #(
      .COORD_BITS    (CB),
      .FRACTION_BITS (FB)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_left    (req_first_left),
      .req_first_top     (req_first_top),
      .req_first_right   (req_first_right),
      .req_first_bottom  (req_first_bottom),
      .req_second_left   (req_second_left),
      .req_second_top    (req_second_top),
      .req_second_right  (req_second_right),
      .req_second_bottom (req_second_bottom),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_overlap_area  (rsp_overlap_area),
      .rsp_union_ratio   (rsp_union_ratio),
      .rsp_first_ratio   (rsp_first_ratio),
      .rsp_union_empty   (rsp_union_empty),
      .rsp_first_empty   (rsp_first_empty)
   );

   // clock
   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // overlap model
   // ---------------------------------------------------------------------

   // clamped extent, zero for inverted or degenerate edges
   function automatic logic [CB-1:0] span_of(logic [CB-1:0] lo, logic [CB-1:0] hi);
      return (hi > lo) ? hi - lo : '0;
   endfunction

   // truncated fixed-point quotient, zero on a zero divisor
   function automatic logic [FB:0] ratio_of(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      if (den == 0)
         return '0;
      quo = (num << FB) / den;
      return quo[FB:0];
   endfunction

   function automatic overlap_type predict_overlap(box_type a, box_type b);
      logic [2*CB-1:0] area_a, area_b, inter;
      logic [2*CB:0]   union_area;
      logic [CB-1:0]   il, it, ir, ib;
      overlap_type     res;
      area_a     = span_of(a.left, a.right) * span_of(a.top, a.bottom);
      area_b     = span_of(b.left, b.right) * span_of(b.top, b.bottom);
      il         = (a.left > b.left) ? a.left : b.left;
      it         = (a.top > b.top) ? a.top : b.top;
      ir         = (a.right < b.right) ? a.right : b.right;
      ib         = (a.bottom < b.bottom) ? a.bottom : b.bottom;
      inter      = span_of(il, ir) * span_of(it, ib);
      union_area = area_a + area_b - inter;
      res.area        = inter;
      res.union_ratio = ratio_of(64'(inter), 64'(union_area));
      res.first_ratio = ratio_of(64'(inter), 64'(area_a));
      res.union_empty = (union_area == 0);
      res.first_empty = (area_a == 0);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------------

   function automatic box_type mk_box(int l, int t, int r, int b);
      box_type bx;
      bx.left   = l[CB-1:0];
      bx.top    = t[CB-1:0];
      bx.right  = r[CB-1:0];
      bx.bottom = b[CB-1:0];
      return bx;
   endfunction

   function automatic int clip(int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // mostly small boxes, some medium, a few up to the full frame
   function automatic int pick_size();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return $urandom_range(0, 16);
      else if (sel < 9)
         return $urandom_range(0, 512);
      return $urandom_range(0, COORD_MAX);
   endfunction

   // random box, now and then inverted on one axis
   function automatic box_type random_box();
      int l, t, w, h;
      box_type bx;
      l  = $urandom_range(0, COORD_MAX);
      t  = $urandom_range(0, COORD_MAX);
      w  = pick_size();
      h  = pick_size();
      bx = mk_box(l, t, clip(l + w), clip(t + h));
      case ($urandom_range(0, 11))
         0: bx = mk_box(bx.right, bx.top, bx.left, bx.bottom);
         1: bx = mk_box(bx.left, bx.bottom, bx.right, bx.top);
         default: ;
      endcase
      return bx;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // one request word, with burst and gap shaping on the sender side
   task automatic send_pair(box_type a, box_type b);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_first_left    <= a.left;
      req_first_top     <= a.top;
      req_first_right   <= a.right;
      req_first_bottom  <= a.bottom;
      req_second_left   <= b.left;
      req_second_top    <= b.top;
      req_second_right  <= b.right;
      req_second_bottom <= b.bottom;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // receiver stall pattern, reloaded whenever stall_tick wraps to zero
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_tick == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = $urandom() & $urandom();
            default: stall_pattern = $urandom() | $urandom();
         endcase
      end
      rsp_ready <= stall_pattern[stall_tick];
      stall_tick = stall_tick + 1;
   end

   // ---------------------------------------------------------------------
   // monitor: queue a prediction per accepted pair, check each result word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      overlap_type want;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1)
            pending_overlaps.push_back(predict_overlap(
               mk_box(req_first_left, req_first_top, req_first_right, req_first_bottom),
               mk_box(req_second_left, req_second_top, req_second_right,
                      req_second_bottom)));
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_overlaps.size() == 0) begin
               report_mismatch("result word with no pending pair");
            end else begin
               want = pending_overlaps.pop_front();
               if (rsp_overlap_area !== want.area)
                  report_mismatch($sformatf("overlap_area got %0d want %0d",
                                            rsp_overlap_area, want.area));
               if (rsp_union_ratio !== want.union_ratio)
                  report_mismatch($sformatf("union_ratio got %0d want %0d",
                                            rsp_union_ratio, want.union_ratio));
               if (rsp_first_ratio !== want.first_ratio)
                  report_mismatch($sformatf("first_ratio got %0d want %0d",
                                            rsp_first_ratio, want.first_ratio));
               if (rsp_union_empty !== want.union_empty)
                  report_mismatch($sformatf("union_empty got %b want %b",
                                            rsp_union_empty, want.union_empty));
               if (rsp_first_empty !== want.first_empty)
                  report_mismatch($sformatf("first_empty got %b want %b",
                                            rsp_first_empty, want.first_empty));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty, inverted, nested, touching, full-frame and truncation corners
   task automatic test_directed();
      send_pair(mk_box(0, 0, 0, 0), mk_box(0, 0, 0, 0));
      send_pair(mk_box(0, 0, COORD_MAX, COORD_MAX), mk_box(0, 0, COORD_MAX, COORD_MAX));
      send_pair(mk_box(0, 0, COORD_MAX, COORD_MAX), mk_box(0, 0, 0, 0));
      send_pair(mk_box(0, 0, 0, 0), mk_box(0, 0, COORD_MAX, COORD_MAX));
      send_pair(mk_box(100, 0, 50, 100), mk_box(0, 0, 200, 200));
      send_pair(mk_box(0, 100, 100, 50), mk_box(0, 0, 200, 200));
      send_pair(mk_box(100, 100, 50, 50), mk_box(300, 300, 200, 200));
      send_pair(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_pair(mk_box(0, 0, 10, 10), mk_box(20, 20, 30, 30));
      send_pair(mk_box(0, 0, 10, 10), mk_box(10, 0, 20, 10));
      send_pair(mk_box(10, 10, 20, 20), mk_box(0, 0, 100, 100));
      send_pair(mk_box(0, 0, 100, 100), mk_box(10, 10, 20, 20));
      send_pair(mk_box(0, 0, 3, 1), mk_box(1, 0, 4, 1));
      send_pair(mk_box(5, 5, 6, 6), mk_box(5, 5, 6, 6));
      send_pair(mk_box(7, 7, 8, 8), mk_box(0, 0, COORD_MAX, COORD_MAX));
      send_pair(mk_box('h0AAA, 'h0AAA, 'h1555, 'h1555), mk_box('h1555, 'h1555, 'h0AAA, 'h0AAA));
      send_pair(mk_box(0, 'h0AAA, 'h1555, 'h1555), mk_box('h0AAA, 0, COORD_MAX, 'h1555));
      send_pair(mk_box(0, 0, COORD_MAX, 1), mk_box(COORD_MAX - 1, 0, COORD_MAX, COORD_MAX));
   endtask

   // second box placed around the first so that most pairs overlap
   task automatic test_overlapping_pairs(int unsigned count);
      box_type a;
      int      w, h, dl, dt, dr, db;
      repeat (count) begin
         a  = random_box();
         w  = span_of(a.left, a.right) + 2;
         h  = span_of(a.top, a.bottom) + 2;
         dl = int'($urandom_range(0, 2 * w)) - w;
         dt = int'($urandom_range(0, 2 * h)) - h;
         dr = int'($urandom_range(0, 2 * w)) - w;
         db = int'($urandom_range(0, 2 * h)) - h;
         send_pair(a, mk_box(clip(a.left + dl), clip(a.top + dt),
                             clip(a.right + dr), clip(a.bottom + db)));
      end
   endtask

   // free coordinates, so every field bit toggles and inversions are common
   task automatic test_raw_coordinates(int unsigned count);
      repeat (count)
         send_pair(mk_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX)),
                   mk_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX)));
   endtask

   // pairs that share edges: identical, touching, nested or zero-width
   task automatic test_shared_edges(int unsigned count);
      box_type a, b;
      repeat (count) begin
         a = random_box();
         case ($urandom_range(0, 5))
            0: b = a;
            1: b = mk_box(a.right, a.top, clip(a.right + pick_size()), a.bottom);
            2: b = mk_box(a.left, a.bottom, a.right, clip(a.bottom + pick_size()));
            3: b = mk_box(a.left, a.top, a.left, a.bottom);
            4: b = mk_box(clip(a.left - pick_size()), clip(a.top - pick_size()),
                          clip(a.right + pick_size()), clip(a.bottom + pick_size()));
            default: b = mk_box(a.left, a.top, clip(a.left + pick_size()),
                                clip(a.top + pick_size()));
         endcase
         if ($urandom_range(0, 1))
            send_pair(a, b);
         else
            send_pair(b, a);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_first_left    = '0;
      req_first_top     = '0;
      req_first_right   = '0;
      req_first_bottom  = '0;
      req_second_left   = '0;
      req_second_top    = '0;
      req_second_right  = '0;
      req_second_bottom = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_overlapping_pairs(550);
      test_raw_coordinates(275);
      test_shared_edges(275);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_overlaps.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0)
         $display("** box_overlap_ratios_core: PASSED **");
      else
         $display("** box_overlap_ratios_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("timeout with %0d words still pending", pending_overlaps.size());
      $display("** box_overlap_ratios_core: FAILED **");
      $finish;
   end

endmodule
